// ===== sv/assert_macros.svh =====
// Assertion macros for the resource lock table, included by its top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/rlt_pkg.sv =====
// Package of shared types, codes and default sizes for the resource lock table.
package rlt_pkg;

  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_KEY_BITS    = 32;
  localparam int DEF_USER_BITS   = 8;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_REGISTER = 2'd0;
  localparam func_t FUNC_LOCK     = 2'd1;
  localparam func_t FUNC_UNLOCK   = 2'd2;
  localparam func_t FUNC_DELETE   = 2'd3;

  typedef logic [2:0] event_t;
  localparam event_t EV_INSERTED   = 3'd0;
  localparam event_t EV_GRANTED    = 3'd1;
  localparam event_t EV_DENIED     = 3'd2;
  localparam event_t EV_NOT_FOUND  = 3'd3;
  localparam event_t EV_TABLE_FULL = 3'd4;
  localparam event_t EV_DELETED    = 3'd5;
  localparam event_t EV_DONE       = 3'd6;

  // Strobes from the controller to the entry store.
  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic owner_we;
  } mem_ctl_t;

endpackage

// ===== sv/rlt_store.sv =====
// Entry store: key and owner memories with one write port and a registered read port.
module rlt_store #(
  parameter int TABLE_DEPTH = rlt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = rlt_pkg::DEF_KEY_BITS,
  parameter int USER_BITS   = rlt_pkg::DEF_USER_BITS
) (
  input  logic                           clk,
  input  rlt_pkg::mem_ctl_t              ctl,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic [KEY_BITS-1:0]            wr_key,
  input  logic [USER_BITS-1:0]           wr_owner,
  output logic [KEY_BITS-1:0]            rd_key,
  output logic [USER_BITS-1:0]           rd_owner
);

  logic [KEY_BITS-1:0]  key_mem   [TABLE_DEPTH];
  logic [USER_BITS-1:0] owner_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (ctl.owner_we) begin
      owner_mem[wr_addr] <= wr_owner;
    end
  end

  // The controller never reads the entry it writes in the same cycle.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_owner <= owner_mem[rd_addr];
    end
  end

endmodule

// ===== sv/resource_lock_table.sv =====
// Top level of the resource lock table: command sequencer around the entry store.
//
// A command transaction is taken at a rising clock edge where start is high and busy is
// low; func, resource_key and user_code are sampled at that edge. Commands are register
// (insert a key or overwrite its owner), lock (grant a key with no owner), unlock (release
// every entry of a user) and delete (remove every entry of a user, one deleted event per
// key in ascending key order, then a done event).
// Each result is shown for exactly one cycle with event_strobe high, together with
// event_res, event_key and last; the receiver cannot stall, so nothing is held back.
// Each pass walks the whole table through the key and owner memories, one entry per
// cycle, the read data coming from the registered read port of the store.
// Register and lock make one pass and show their single result; the next command can be
// taken in the cycle in which that result is shown. Unlock makes one pass and gives no
// result. Delete of a user with n entries makes n + 1 passes, each but the last ending
// in a deleted event and the last pass ending in done.
// Reset clears the valid bit of every entry at once; no clearing pass is needed and the
// block can take a command in the first cycle after reset.
module resource_lock_table #(
  parameter int TABLE_DEPTH = rlt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = rlt_pkg::DEF_KEY_BITS,
  parameter int USER_BITS   = rlt_pkg::DEF_USER_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  rlt_pkg::func_t       func,
  input  logic [KEY_BITS-1:0]  resource_key,
  input  logic [USER_BITS-1:0] user_code,
  output logic                 event_strobe,
  output rlt_pkg::event_t      event_res,
  output logic [KEY_BITS-1:0]  event_key,
  output logic                 last
);

`include "assert_macros.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;

  // Latched command.
  rlt_pkg::func_t       cmd_func;
  logic [KEY_BITS-1:0]  cmd_key;
  logic [USER_BITS-1:0] cmd_user;

  // Valid bit of every entry, held in flip-flops so reset clears them at once.
  logic [TABLE_DEPTH-1:0] valid;

  // Scan pointers: rd_idx issues reads, chk_idx tags the data now coming back.
  logic [IDX_W-1:0] rd_idx;
  logic             rd_active;
  logic [IDX_W-1:0] chk_idx;
  logic             chk_vld;

  // What the scan has found so far. For delete, the match is the owned entry with the
  // smallest key seen in this pass.
  logic                 match_found;
  logic [IDX_W-1:0]     match_idx;
  logic [USER_BITS-1:0] match_owner;
  logic [KEY_BITS-1:0]  best_key;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;

  // Store interface.
  rlt_pkg::mem_ctl_t    mem_ctl;
  logic [IDX_W-1:0]     wr_addr;
  logic [KEY_BITS-1:0]  wr_key;
  logic [USER_BITS-1:0] wr_owner;
  logic [KEY_BITS-1:0]  rd_key;
  logic [USER_BITS-1:0] rd_owner;

  logic accept;
  logic ent_valid;
  logic key_hit;
  logic own_hit;
  logic reg_finish;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign ent_valid = valid[chk_idx];
  assign key_hit   = ent_valid && (rd_key == cmd_key);
  assign own_hit   = ent_valid && (rd_owner == cmd_user);

  // Finish cycle of a register command, the only place a key is written.
  assign reg_finish = (state == ST_FINISH) && (cmd_func == rlt_pkg::FUNC_REGISTER);

  rlt_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .USER_BITS   (USER_BITS)
  ) u_store (
    .clk      (clk),
    .ctl      (mem_ctl),
    .rd_addr  (rd_idx),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_owner (wr_owner),
    .rd_key   (rd_key),
    .rd_owner (rd_owner)
  );

  // Write port. During an unlock scan the owner of each owned entry is cleared as its data
  // returns; the read pointer is already past that entry, so no access overlaps it. The
  // closing write of register and lock lands in the finish cycle, before any new read.
  always_comb begin
    mem_ctl.rd_en    = (state == ST_SCAN) && rd_active;
    mem_ctl.key_we   = 1'b0;
    mem_ctl.owner_we = 1'b0;
    wr_addr          = chk_idx;
    wr_key           = cmd_key;
    wr_owner         = '0;
    if (state == ST_SCAN) begin
      if (chk_vld && (cmd_func == rlt_pkg::FUNC_UNLOCK) && own_hit) begin
        mem_ctl.owner_we = 1'b1;
      end
    end else if (state == ST_FINISH) begin
      wr_owner = cmd_user;
      unique case (cmd_func)
        rlt_pkg::FUNC_REGISTER: begin
          if (match_found) begin
            mem_ctl.owner_we = 1'b1;
            wr_addr          = match_idx;
          end else if (free_found) begin
            mem_ctl.key_we   = 1'b1;
            mem_ctl.owner_we = 1'b1;
            wr_addr          = free_idx;
          end
        end
        rlt_pkg::FUNC_LOCK: begin
          if (match_found && (match_owner == '0)) begin
            mem_ctl.owner_we = 1'b1;
            wr_addr          = match_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer, scan bookkeeping and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      valid       <= '0;
      rd_active   <= 1'b0;
      chk_vld     <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state       <= ST_SCAN;
            rd_idx      <= '0;
            rd_active   <= 1'b1;
            chk_vld     <= 1'b0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
          end
        end
        ST_SCAN: begin
          chk_vld <= mem_ctl.rd_en;
          chk_idx <= rd_idx;
          if (rd_active) begin
            rd_idx <= rd_idx + 1'b1;
            if (rd_idx == LAST_IDX) begin
              rd_active <= 1'b0;
            end
          end
          if (chk_vld) begin
            unique case (cmd_func)
              rlt_pkg::FUNC_REGISTER: begin
                if (key_hit) begin
                  match_found <= 1'b1;
                  match_idx   <= chk_idx;
                end
                if (!ent_valid && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= chk_idx;
                end
              end
              rlt_pkg::FUNC_LOCK: begin
                if (key_hit) begin
                  match_found <= 1'b1;
                  match_idx   <= chk_idx;
                  match_owner <= rd_owner;
                end
              end
              rlt_pkg::FUNC_DELETE: begin
                if (own_hit && (!match_found || (rd_key < best_key))) begin
                  match_found <= 1'b1;
                  match_idx   <= chk_idx;
                  best_key    <= rd_key;
                end
              end
              default: begin
              end
            endcase
            if (chk_idx == LAST_IDX) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          state <= ST_IDLE;
          if (cmd_func == rlt_pkg::FUNC_REGISTER) begin
            if (!match_found && free_found) begin
              valid[free_idx] <= 1'b1;
            end
          end else if (cmd_func == rlt_pkg::FUNC_DELETE) begin
            if (match_found) begin
              // Remove the smallest owned key and walk the table again.
              valid[match_idx] <= 1'b0;
              state            <= ST_SCAN;
              rd_idx           <= '0;
              rd_active        <= 1'b1;
              chk_vld          <= 1'b0;
              match_found      <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Command latch.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_func <= func;
      cmd_key  <= resource_key;
      cmd_user <= user_code;
    end
  end

  // Result register: one result per finish cycle of register, lock or delete, shown in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      event_strobe <= 1'b0;
    end else begin
      event_strobe <= (state == ST_FINISH) && (cmd_func != rlt_pkg::FUNC_UNLOCK);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      event_key <= cmd_key;
      last      <= 1'b1;
      unique case (cmd_func)
        rlt_pkg::FUNC_REGISTER: begin
          event_res <= (match_found || free_found) ? rlt_pkg::EV_INSERTED
                                                   : rlt_pkg::EV_TABLE_FULL;
        end
        rlt_pkg::FUNC_LOCK: begin
          if (!match_found) begin
            event_res <= rlt_pkg::EV_NOT_FOUND;
          end else if (match_owner == '0) begin
            event_res <= rlt_pkg::EV_GRANTED;
          end else begin
            event_res <= rlt_pkg::EV_DENIED;
          end
        end
        rlt_pkg::FUNC_DELETE: begin
          if (match_found) begin
            event_res <= rlt_pkg::EV_DELETED;
            event_key <= best_key;
            last      <= 1'b0;
          end else begin
            event_res <= rlt_pkg::EV_DONE;
            event_key <= '0;
          end
        end
        default: begin
          event_res <= rlt_pkg::EV_DONE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_scan, clk, rst, accept, state == ST_SCAN, "command not started")
  `ASSERT_IMPLY(a_mid_scan, clk, rst, event_strobe && !last, state == ST_SCAN, "scan expected")
  `ASSERT_IMPLY(a_last_idle, clk, rst, event_strobe && last, !busy, "busy after last")
  `ASSERT_IMPLY(a_data_in_scan, clk, rst, chk_vld, state == ST_SCAN, "data outside scan")
  `ASSERT_IMPLY(a_key_write, clk, rst, mem_ctl.key_we, reg_finish, "stray key write")

endmodule

// ===== verif/resource_lock_table_checker.sv =====
// Checker for the resource lock table: predicts every result and compares it with the block.
`timescale 1ns / 100ps

module resource_lock_table_checker #(
  parameter int TABLE_DEPTH = rlt_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = rlt_pkg::DEF_KEY_BITS,
  parameter int USER_BITS   = rlt_pkg::DEF_USER_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  rlt_pkg::func_t       func,
  input  logic [KEY_BITS-1:0]  resource_key,
  input  logic [USER_BITS-1:0] user_code,
  input  logic                 event_strobe,
  input  rlt_pkg::event_t      event_res,
  input  logic [KEY_BITS-1:0]  event_key,
  input  logic                 last,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen
);

  typedef struct {
    rlt_pkg::event_t     res;
    logic [KEY_BITS-1:0] key;
    logic                last;
  } lock_event_t;

  lock_event_t expected_events[$];

  logic                 table_valid [TABLE_DEPTH];
  logic [KEY_BITS-1:0]  table_key   [TABLE_DEPTH];
  logic [USER_BITS-1:0] table_owner [TABLE_DEPTH];

  int mismatch_total = 0;
  int seen_total = 0;

  task automatic report_mismatch(input string msg);
    mismatch_total++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic push_event(input rlt_pkg::event_t res, input logic [KEY_BITS-1:0] key,
                            input logic lst);
    lock_event_t ev;
    ev.res = res;
    ev.key = key;
    ev.last = lst;
    expected_events.push_back(ev);
  endtask

  function automatic int slot_of_key(input logic [KEY_BITS-1:0] key);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (table_valid[i] && table_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int lowest_free_slot();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!table_valid[i]) return i;
    end
    return -1;
  endfunction

  // Updates the predicted table for one accepted command and queues its results.
  task automatic apply_command(input rlt_pkg::func_t f, input logic [KEY_BITS-1:0] key,
                               input logic [USER_BITS-1:0] user);
    int slot;
    int best;
    case (f)
      rlt_pkg::FUNC_REGISTER: begin
        slot = slot_of_key(key);
        if (slot < 0) begin
          slot = lowest_free_slot();
          if (slot >= 0) begin
            table_valid[slot] = 1'b1;
            table_key[slot] = key;
          end
        end
        if (slot < 0) begin
          push_event(rlt_pkg::EV_TABLE_FULL, key, 1'b1);
        end else begin
          table_owner[slot] = user;
          push_event(rlt_pkg::EV_INSERTED, key, 1'b1);
        end
      end
      rlt_pkg::FUNC_LOCK: begin
        slot = slot_of_key(key);
        if (slot < 0) begin
          push_event(rlt_pkg::EV_NOT_FOUND, key, 1'b1);
        end else if (table_owner[slot] == '0) begin
          table_owner[slot] = user;
          push_event(rlt_pkg::EV_GRANTED, key, 1'b1);
        end else begin
          push_event(rlt_pkg::EV_DENIED, key, 1'b1);
        end
      end
      rlt_pkg::FUNC_UNLOCK: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (table_valid[i] && table_owner[i] == user) table_owner[i] = '0;
        end
      end
      default: begin
        do begin
          best = -1;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (table_valid[i] && table_owner[i] == user &&
                (best < 0 || table_key[i] < table_key[best])) best = i;
          end
          if (best >= 0) begin
            table_valid[best] = 1'b0;
            push_event(rlt_pkg::EV_DELETED, table_key[best], 1'b0);
          end
        end while (best >= 0);
        push_event(rlt_pkg::EV_DONE, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_event();
    lock_event_t exp_ev;
    seen_total++;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected result res=%0d key=%h last=%b",
                                event_res, event_key, last));
    end else begin
      exp_ev = expected_events.pop_front();
      if (event_res !== exp_ev.res)
        report_mismatch($sformatf("event_res %0d, expected %0d", event_res, exp_ev.res));
      if (event_key !== exp_ev.key)
        report_mismatch($sformatf("event_key %h, expected %h", event_key, exp_ev.key));
      if (last !== exp_ev.last)
        report_mismatch($sformatf("last %b, expected %b", last, exp_ev.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        table_valid[i] = 1'b0;
        table_key[i] = '0;
        table_owner[i] = '0;
      end
      expected_events.delete();
    end else begin
      // A result at this edge belongs to an earlier command, so compare before predicting.
      if (event_strobe) check_event();
      if (start && !busy) apply_command(func, resource_key, user_code);
    end
    pending <= expected_events.size();
    fail_count <= mismatch_total;
    results_seen <= seen_total;
  end

endmodule

// ===== verif/resource_lock_table_tb.sv =====
// Top of the resource lock table testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module resource_lock_table_tb;

  localparam int TABLE_DEPTH = rlt_pkg::DEF_TABLE_DEPTH;
  localparam int KEY_BITS    = rlt_pkg::DEF_KEY_BITS;
  localparam int USER_BITS   = rlt_pkg::DEF_USER_BITS;
  localparam int KEY_POOL    = 40;
  localparam int RANDOM_CMDS = 76;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  rlt_pkg::func_t       func = rlt_pkg::FUNC_REGISTER;
  logic [KEY_BITS-1:0]  resource_key = '0;
  logic [USER_BITS-1:0] user_code = '0;
  logic                 event_strobe;
  rlt_pkg::event_t      event_res;
  logic [KEY_BITS-1:0]  event_key;
  logic                 last;

  int fail_count;
  int pending;
  int results_seen;

  // Commands sent so far, in total and per function code.
  int sent_total = 0;
  int sent_per_func[4] = '{0, 0, 0, 0};

  logic [KEY_BITS-1:0] key_pool [KEY_POOL];
  logic [KEY_BITS-1:0] fill_keys [TABLE_DEPTH];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  resource_lock_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .USER_BITS  (USER_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .resource_key(resource_key),
    .user_code   (user_code),
    .event_strobe(event_strobe),
    .event_res   (event_res),
    .event_key   (event_key),
    .last        (last)
  );

  // The checker sees the same pins as the block and keeps its own copy of the table.
  resource_lock_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .USER_BITS  (USER_BITS)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .resource_key(resource_key),
    .user_code   (user_code),
    .event_strobe(event_strobe),
    .event_res   (event_res),
    .event_key   (event_key),
    .last        (last),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  // Sends one command transaction. All calls start right after a rising edge. Before the
  // command the sender may drop start for a while; the gap length is drawn wide so that
  // start rises at every phase of a busy table walk. A stretch at the end of the random
  // part runs with no gaps at all, so commands go in back to back.
  task automatic send_command(input rlt_pkg::func_t f, input logic [KEY_BITS-1:0] key,
                              input logic [USER_BITS-1:0] user);
    int gap;
    gap = 0;
    if (!(sent_total >= 90 && sent_total < 130) && $urandom_range(0, 99) < 25)
      gap = $urandom_range(1, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    resource_key <= key;
    user_code <= user;
    // The transaction completes at the first edge that sees busy low with start high.
    do @(posedge clk); while (busy);
    sent_total++;
    sent_per_func[f]++;
  endtask

  // Picks a user code: mostly a handful of small codes so that owners collide, plus the
  // no-user code, the top code and now and then any code at all.
  function automatic logic [USER_BITS-1:0] pick_user();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return {USER_BITS{1'b1}};
    if (r == 2) return USER_BITS'($urandom_range(0, 255));
    return USER_BITS'($urandom_range(1, 4));
  endfunction

  initial begin
    int r;
    logic [KEY_BITS-1:0] spare_key;
    logic clash;

    key_pool[0] = '0;
    key_pool[1] = {KEY_BITS{1'b1}};
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. On an empty table a lock finds nothing and a delete gives only done.
    send_command(rlt_pkg::FUNC_LOCK, 32'h0000_0000, 8'd1);
    send_command(rlt_pkg::FUNC_DELETE, 32'h0, 8'd3);
    send_command(rlt_pkg::FUNC_REGISTER, 32'h0000_0000, 8'd0);
    send_command(rlt_pkg::FUNC_REGISTER, 32'hFFFF_FFFF, 8'hFF);
    send_command(rlt_pkg::FUNC_REGISTER, 32'h8000_0001, 8'd0);
    // A lock by the no-user code is granted but leaves the entry free, so the next
    // lock is granted too; a second lock by the new owner is denied.
    send_command(rlt_pkg::FUNC_LOCK, 32'h0000_0000, 8'd0);
    send_command(rlt_pkg::FUNC_LOCK, 32'h0000_0000, 8'd5);
    send_command(rlt_pkg::FUNC_LOCK, 32'h0000_0000, 8'd5);
    send_command(rlt_pkg::FUNC_LOCK, 32'hFFFF_FFFF, 8'd1);
    // Registering a present key only overwrites its owner.
    send_command(rlt_pkg::FUNC_REGISTER, 32'hFFFF_FFFF, 8'd5);
    send_command(rlt_pkg::FUNC_UNLOCK, 32'h0, 8'd0);
    send_command(rlt_pkg::FUNC_UNLOCK, 32'h0, 8'd200);
    // Deleting the no-user code removes the free entries; deleting user 5 removes two
    // keys and reports them smallest first.
    send_command(rlt_pkg::FUNC_DELETE, 32'h0, 8'd0);
    send_command(rlt_pkg::FUNC_DELETE, 32'h0, 8'd5);
    send_command(rlt_pkg::FUNC_UNLOCK, 32'h0, 8'hFF);

    // Fill every entry with one owner. The low bits keep the keys distinct.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      fill_keys[i] = ($urandom & ~32'h1F) | i;
      send_command(rlt_pkg::FUNC_REGISTER, fill_keys[i], 8'd9);
    end
    do begin
      spare_key = $urandom;
      clash = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) if (fill_keys[i] == spare_key) clash = 1'b1;
    end while (clash);
    // A new key cannot go in, but a present key can still change owner in a full table.
    send_command(rlt_pkg::FUNC_REGISTER, spare_key, 8'd9);
    send_command(rlt_pkg::FUNC_REGISTER, fill_keys[7], 8'd2);
    send_command(rlt_pkg::FUNC_LOCK, fill_keys[3], 8'd2);
    send_command(rlt_pkg::FUNC_UNLOCK, 32'h0, 8'd2);
    send_command(rlt_pkg::FUNC_LOCK, fill_keys[7], 8'd3);
    // Nearly the longest delete: every entry but one goes.
    send_command(rlt_pkg::FUNC_DELETE, 32'h0, 8'd9);
    send_command(rlt_pkg::FUNC_DELETE, 32'h0, 8'd3);

    // Random part: mostly registers and locks on a shared pool of keys so that entries
    // are found, owned and denied, with unlocks and deletes clearing users out.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_command(rlt_pkg::FUNC_REGISTER,
                     ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL-1)]
                                                  : 32'($urandom),
                     pick_user());
      end else if (r < 75) begin
        send_command(rlt_pkg::FUNC_LOCK,
                     ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL-1)]
                                                  : 32'($urandom),
                     pick_user());
      end else if (r < 85) begin
        send_command(rlt_pkg::FUNC_UNLOCK, $urandom, pick_user());
      end else begin
        send_command(rlt_pkg::FUNC_DELETE, $urandom, pick_user());
      end
    end
    start <= 1'b0;

    // Drain: every expected result must arrive and the block must go idle. Then a full
    // table walk more to catch any stray result.
    do @(posedge clk); while (pending != 0 || busy);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("Covered %0d commands: %0d register, %0d lock, %0d unlock, %0d delete,",
             sent_total, sent_per_func[rlt_pkg::FUNC_REGISTER],
             sent_per_func[rlt_pkg::FUNC_LOCK], sent_per_func[rlt_pkg::FUNC_UNLOCK],
             sent_per_func[rlt_pkg::FUNC_DELETE]);
    $display("with %0d results checked, a full table and a delete of %0d entries.",
             results_seen, TABLE_DEPTH - 1);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
